/* rtl/nfa_pkg.sv */
// Shared constants and controller/datapath interface types for the NOR flash array model.
package nfa_pkg;

  localparam int ACT_W  = 2;
  localparam int ADDR_W = 15;
  localparam int LEN_W  = 16;
  localparam int DATA_W = 32;
  localparam int PAGE_W = 7;
  localparam int CNT_W  = 16;

  localparam logic [ACT_W-1:0] ACT_READ  = 2'd0;
  localparam logic [ACT_W-1:0] ACT_STORE = 2'd1;
  localparam logic [ACT_W-1:0] ACT_ERASE = 2'd2;

  localparam logic [DATA_W-1:0] ERASED_WORD = '1;

  typedef struct packed {
    logic load_in;
    logic clr_step;
    logic mem_rd;
    logic st_write;
    logic er_start;
    logic er_step;
    logic out_fire;
    logic out_bad;
    logic out_rdata;
  } nfa_cmd_t;

  typedef struct packed {
    logic rw_go;
    logic er_go;
    logic bad;
    logic is_read;
    logic clr_done;
    logic er_done;
  } nfa_sts_t;

endpackage

/* rtl/nfa_ram.sv */
// Generic single-write, single-read RAM with registered read data.
module nfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16384
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/nfa_ctrl.sv */
// Controller state machine: clear sweep, transaction decode, read-modify-write and erase walk.
module nfa_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  nfa_pkg::nfa_sts_t sts,
  output logic              busy,
  output nfa_pkg::nfa_cmd_t cmd
);

  typedef enum logic [4:0] {
    S_CLEAR = 5'b00001,
    S_IDLE  = 5'b00010,
    S_EXEC  = 5'b00100,
    S_WAIT  = 5'b01000,
    S_ERASE = 5'b10000
  } nfa_state_t;

  nfa_state_t state_r;
  nfa_state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    case (state_r)
      S_CLEAR: begin
        cmd.clr_step = 1'b1;
        if (sts.clr_done) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_EXEC;
        end
      end
      S_EXEC: begin
        if (sts.rw_go) begin
          cmd.mem_rd = 1'b1;
          state_nxt  = S_WAIT;
        end else if (sts.er_go) begin
          cmd.er_start = 1'b1;
          state_nxt    = S_ERASE;
        end else begin
          cmd.out_fire = 1'b1;
          cmd.out_bad  = sts.bad;
          state_nxt    = S_IDLE;
        end
      end
      S_WAIT: begin
        cmd.out_fire  = 1'b1;
        cmd.out_rdata = sts.is_read;
        cmd.st_write  = !sts.is_read;
        state_nxt     = S_IDLE;
      end
      S_ERASE: begin
        cmd.er_step = 1'b1;
        if (sts.er_done) begin
          cmd.out_fire = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign busy = (state_r != S_IDLE);

  a_one_result: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.out_fire |=> !cmd.out_fire)
    else $error("two results in consecutive cycles");

  a_wait_after_exec: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WAIT) |-> ($past(state_r) == S_EXEC))
    else $error("word access without decode");

  a_erase_ends: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ERASE && sts.er_done) |=> (state_r == S_IDLE))
    else $error("erase walk overran its last word");

  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.load_in) |-> (state_r == S_IDLE && !cmd.out_fire))
    else $error("transaction accepted outside idle");

endmodule

/* rtl/nfa_dp.sv */
// Datapath: transaction registers, range checks, address walker, flash array and result registers.
module nfa_dp #(
  parameter int PAGE_WORDS  = 256,
  parameter int ARRAY_PAGES = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  nfa_pkg::nfa_cmd_t                  cmd,
  output nfa_pkg::nfa_sts_t                  sts,
  input  logic [nfa_pkg::ACT_W-1:0]          in_action,
  input  logic [nfa_pkg::ADDR_W-1:0]         in_word_addr,
  input  logic [nfa_pkg::LEN_W-1:0]          in_run_length,
  input  logic [nfa_pkg::LEN_W-1:0]          in_run_offset,
  input  logic [nfa_pkg::DATA_W-1:0]         in_data_word,
  input  logic [nfa_pkg::PAGE_W-1:0]         in_page_index,
  input  logic [nfa_pkg::CNT_W-1:0]          in_page_count,
  output logic                               out_strobe,
  output logic                               out_status,
  output logic [nfa_pkg::DATA_W-1:0]         out_read_data
);

  localparam int TOTAL_WORDS = PAGE_WORDS * ARRAY_PAGES;
  localparam int AW          = $clog2(TOTAL_WORDS);
  localparam int CHK_W       = (AW + 1 > nfa_pkg::LEN_W + 1) ? AW + 1 : nfa_pkg::LEN_W + 1;
  localparam int PG_W        = nfa_pkg::CNT_W + 1;

  logic [nfa_pkg::ACT_W-1:0]  action_r;
  logic [nfa_pkg::ADDR_W-1:0] word_addr_r;
  logic [nfa_pkg::LEN_W-1:0]  run_length_r;
  logic [nfa_pkg::LEN_W-1:0]  run_offset_r;
  logic [nfa_pkg::DATA_W-1:0] data_word_r;
  logic [nfa_pkg::PAGE_W-1:0] page_index_r;
  logic [nfa_pkg::CNT_W-1:0]  page_count_r;

  logic [AW-1:0] addr_r;
  logic [AW-1:0] addr_nxt;
  logic [AW-1:0] last_r;

  logic                       out_strobe_r;
  logic                       out_status_r;
  logic [nfa_pkg::DATA_W-1:0] out_read_data_r;

  logic [CHK_W-1:0] rw_end;
  logic [CHK_W-1:0] rw_full;
  logic [AW-1:0]    rw_addr;
  logic [PG_W-1:0]  pg_end;
  logic [31:0]      er_first;
  logic [31:0]      er_last;
  logic             is_rw;
  logic             is_er;
  logic             rw_bad;
  logic             er_bad;

  logic                       mem_we;
  logic [AW-1:0]              mem_waddr;
  logic [nfa_pkg::DATA_W-1:0] mem_wdata;
  logic [nfa_pkg::DATA_W-1:0] mem_rdata;

  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      action_r     <= in_action;
      word_addr_r  <= in_word_addr;
      run_length_r <= in_run_length;
      run_offset_r <= in_run_offset;
      data_word_r  <= in_data_word;
      page_index_r <= in_page_index;
      page_count_r <= in_page_count;
    end
  end

  assign is_rw   = (action_r == nfa_pkg::ACT_READ) || (action_r == nfa_pkg::ACT_STORE);
  assign is_er   = (action_r == nfa_pkg::ACT_ERASE);
  assign rw_end  = CHK_W'(word_addr_r) + CHK_W'(run_length_r);
  assign rw_full = CHK_W'(word_addr_r) + CHK_W'(run_offset_r);
  assign rw_addr = rw_full[AW-1:0];
  assign rw_bad  = rw_end > CHK_W'(TOTAL_WORDS);
  assign pg_end  = PG_W'(page_index_r) + PG_W'(page_count_r);
  assign er_bad  = pg_end > PG_W'(ARRAY_PAGES);

  assign er_first = 32'(page_index_r) * 32'(PAGE_WORDS);
  assign er_last  = 32'(pg_end) * 32'(PAGE_WORDS) - 32'd1;

  always_comb begin
    sts.rw_go    = is_rw && !rw_bad && (run_offset_r < run_length_r)
                   && (rw_full < CHK_W'(TOTAL_WORDS));
    sts.er_go    = is_er && !er_bad && (page_count_r != '0);
    sts.bad      = (is_rw && rw_bad) || (is_er && er_bad) || (!is_rw && !is_er);
    sts.is_read  = (action_r == nfa_pkg::ACT_READ);
    sts.clr_done = (addr_r == AW'(TOTAL_WORDS - 1));
    sts.er_done  = (addr_r == last_r);
  end

  always_comb begin
    addr_nxt = addr_r;
    if (cmd.er_start) begin
      addr_nxt = er_first[AW-1:0];
    end else if (cmd.clr_step || cmd.er_step) begin
      addr_nxt = addr_r + AW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      addr_r <= '0;
    end else begin
      addr_r <= addr_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.er_start) begin
      last_r <= er_last[AW-1:0];
    end
  end

  assign mem_we    = cmd.clr_step || cmd.er_step || cmd.st_write;
  assign mem_waddr = cmd.st_write ? rw_addr : addr_r;
  assign mem_wdata = cmd.st_write ? (mem_rdata & data_word_r) : nfa_pkg::ERASED_WORD;

  nfa_ram #(
    .WIDTH (nfa_pkg::DATA_W),
    .DEPTH (TOTAL_WORDS)
  ) u_array (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (cmd.mem_rd),
    .raddr (rw_addr),
    .rdata (mem_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.out_fire;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_fire) begin
      out_status_r    <= cmd.out_bad;
      out_read_data_r <= cmd.out_rdata ? mem_rdata : '0;
    end
  end

  assign out_strobe    = out_strobe_r;
  assign out_status    = out_status_r;
  assign out_read_data = out_read_data_r;

endmodule

/* rtl/nor_flash_array_model.sv */
// Top level of the word-addressed NOR flash array model.
//
//  channel   ports                                   handshake
//  input     in_action .. in_page_count              start high while busy low
//  result    out_status, out_read_data               out_strobe, one cycle, no stall
//
//  Rejected, skipped and zero-page transactions: answered from decode without touching the array.
//  Read: decode, read and result steps, set by the registered read port of the array.
//  Store: a read-modify-write on the same single write port.
//  Erase: one word written per cycle across the selected pages.
//  After reset busy stays high while the array is swept to all ones.
module nor_flash_array_model #(
  parameter int PAGE_WORDS  = 256,
  parameter int ARRAY_PAGES = 64
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  output logic                       busy,
  input  logic [nfa_pkg::ACT_W-1:0]  in_action,
  input  logic [nfa_pkg::ADDR_W-1:0] in_word_addr,
  input  logic [nfa_pkg::LEN_W-1:0]  in_run_length,
  input  logic [nfa_pkg::LEN_W-1:0]  in_run_offset,
  input  logic [nfa_pkg::DATA_W-1:0] in_data_word,
  input  logic [nfa_pkg::PAGE_W-1:0] in_page_index,
  input  logic [nfa_pkg::CNT_W-1:0]  in_page_count,
  output logic                       out_strobe,
  output logic                       out_status,
  output logic [nfa_pkg::DATA_W-1:0] out_read_data
);

  nfa_pkg::nfa_cmd_t cmd;
  nfa_pkg::nfa_sts_t sts;

  nfa_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .sts   (sts),
    .busy  (busy),
    .cmd   (cmd)
  );

  nfa_dp #(
    .PAGE_WORDS  (PAGE_WORDS),
    .ARRAY_PAGES (ARRAY_PAGES)
  ) u_dp (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_action     (in_action),
    .in_word_addr  (in_word_addr),
    .in_run_length (in_run_length),
    .in_run_offset (in_run_offset),
    .in_data_word  (in_data_word),
    .in_page_index (in_page_index),
    .in_page_count (in_page_count),
    .out_strobe    (out_strobe),
    .out_status    (out_status),
    .out_read_data (out_read_data)
  );

endmodule
